// ===== sv/cmcc_pkg.sv =====
package cmcc_pkg;

   // Stream payload widths, in bits.
   localparam int ReqDataW = 96;
   localparam int RspDataW = 88;
   localparam int CsrDataW = 48;
   localparam int CsrIndexW = 1;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] CsrThreshold = 1'd0;
   localparam logic [CsrIndexW-1:0] CsrWeightsEn = 1'd1;

   // Iteration counts of the shared adder.
   localparam int MulSteps = 32;
   localparam int DivSteps = 17;
   localparam int StepW = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_CLOSE,
      ST_DIV,
      ST_EMIT
   } cmcc_state_type;

endpackage

// ===== sv/column_max_change_checker_unit.sv =====
// An element that does not close a column passes through the accept (idle) and difference states.
// Closing a column adds the close state, preceded by a 32-step multiply when weights are enabled.
// Closing the matrix adds 17 divide steps and the emit state, which places the result word.
// Inside a column a new element is accepted only once the previous one has returned the sequencer to idle.
// Synchronous active-high reset clears the sequencer, all running totals and both
// configuration registers; the result register holds no word after reset.
module column_max_change_checker_unit #(
   parameter int MAX_COLUMNS = 65535
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input words.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0 up: value_a[31:0], value_b[63:32], column_weight[95:64].
   input  logic [cmcc_pkg::ReqDataW-1:0] req_tdata,
   // Fields from bit 0 up: last_in_column.
   input  logic                          req_tuser,
   // last_in_matrix.
   input  logic                          req_tlast,
   // Result words.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0 up: max_difference[47:0], changed_columns[63:48],
   // changed_fraction[80:64], zero padding[87:81].
   output logic [cmcc_pkg::RspDataW-1:0] rsp_tdata,
   // Configuration writes.
   input  logic                          csr_we,
   input  logic [cmcc_pkg::CsrIndexW-1:0] csr_index,
   input  logic [cmcc_pkg::CsrDataW-1:0] csr_wdata
);
   import cmcc_pkg::*;

   localparam logic [15:0] MaxCols = 16'(MAX_COLUMNS);

   // Sequencer state.
   cmcc_state_type state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;

   // Latched input word.
   logic [31:0] a_ff, b_ff, weight_ff;
   logic        col_end_ff, mat_end_ff;

   // Configuration.
   logic [47:0] threshold_ff;
   logic        weights_en_ff;

   // Running totals.
   logic [32:0] column_peak_ff, column_peak_in;
   logic [47:0] overall_peak_ff, overall_peak_in;
   logic [15:0] changed_total_ff, changed_total_in;
   logic [15:0] column_total_ff, column_total_in;

   // Shared adder operands and the multiply / divide working registers.
   logic [33:0] alu_a, alu_b, alu_sum;
   logic        alu_sub;
   logic [33:0] acc_hi_ff, acc_hi_in;
   logic [31:0] acc_lo_ff, acc_lo_in;
   logic [15:0] rem_ff, rem_in;
   logic [16:0] dvd_ff, dvd_in;
   logic [16:0] quo_ff, quo_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   // Helper terms.
   logic [32:0] diff, mag;
   logic [47:0] scaled;
   logic [15:0] chg_next, chg_min;
   logic        rsp_free, div_fits;

   function automatic logic [15:0] count_up(input logic [15:0] c);
      return (c < MaxCols) ? c + 16'd1 : MaxCols;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Exact 33-bit difference and its magnitude, at most 2^32 - 1.
   assign diff = {a_ff[31], a_ff} - {b_ff[31], b_ff};
   assign mag  = diff[32] ? (~diff + 33'd1) : diff;

   // Weighted peak: product >> 16, saturated to 48 bits; with weights disabled, the unweighted column peak.
   always_comb begin
      if (weights_en_ff) begin
         scaled = (|acc_hi_ff[33:32]) ? '1 : {acc_hi_ff[31:0], acc_lo_ff[31:16]};
      end else begin
         scaled = {15'd0, column_peak_ff};
      end
   end

   // The one adder, shared by the multiply (add) and the divide (trial subtract).
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_MUL: begin
            alu_a = acc_hi_ff;
            alu_b = {1'b0, column_peak_ff};
         end
         ST_DIV: begin
            alu_a   = {17'd0, rem_ff, dvd_ff[16]};
            alu_b   = {18'd0, column_total_ff};
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end
   assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + {33'd0, alu_sub};
   assign div_fits = !alu_sum[33];

   assign chg_next = (scaled > threshold_ff) ? count_up(changed_total_ff) : changed_total_ff;
   assign chg_min  = (chg_next > count_up(column_total_ff)) ? count_up(column_total_ff)
                                                            : chg_next;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (col_end_ff || mat_end_ff) begin
               state_in = weights_en_ff ? ST_MUL : ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            if (step_ff == StepW'(MulSteps - 1)) state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            state_in = mat_end_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (step_ff == StepW'(DivSteps - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates per state.
   always_comb begin
      step_in          = '0;
      column_peak_in   = column_peak_ff;
      overall_peak_in  = overall_peak_ff;
      changed_total_in = changed_total_ff;
      column_total_in  = column_total_ff;
      acc_hi_in        = acc_hi_ff;
      acc_lo_in        = acc_lo_ff;
      rem_in           = rem_ff;
      dvd_in           = dvd_ff;
      quo_in           = quo_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_DIFF: begin
            if (mag > column_peak_ff) column_peak_in = mag;
            acc_hi_in = '0;
            acc_lo_in = weight_ff;
         end
         ST_MUL: begin
            // Shift-add: add the peak when the low multiplier bit is set, then shift.
            step_in = step_ff + StepW'(1);
            if (acc_lo_ff[0]) begin
               acc_hi_in = {1'b0, alu_sum[33:1]};
               acc_lo_in = {alu_sum[0], acc_lo_ff[31:1]};
            end else begin
               acc_hi_in = {1'b0, acc_hi_ff[33:1]};
               acc_lo_in = {acc_hi_ff[0], acc_lo_ff[31:1]};
            end
         end
         ST_CLOSE: begin
            changed_total_in = chg_next;
            column_total_in  = count_up(column_total_ff);
            if (scaled > overall_peak_ff) overall_peak_in = scaled;
            column_peak_in = '0;
            // The dividend is chg << 16; its bits above 16 are already below the divisor.
            rem_in = {1'b0, chg_min[15:1]};
            dvd_in = {chg_min[0], 16'd0};
            quo_in = '0;
         end
         ST_DIV: begin
            step_in = step_ff + StepW'(1);
            rem_in  = div_fits ? alu_sum[15:0] : {rem_ff[14:0], dvd_ff[16]};
            dvd_in  = {dvd_ff[15:0], 1'b0};
            quo_in  = {quo_ff[15:0], div_fits};
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_data_in      = {7'd0, quo_ff, changed_total_ff, overall_peak_ff};
               rsp_valid_in     = 1'b1;
               column_peak_in   = '0;
               overall_peak_in  = '0;
               changed_total_in = '0;
               column_total_in  = '0;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         threshold_ff     <= '0;
         weights_en_ff    <= 1'b0;
         column_peak_ff   <= '0;
         overall_peak_ff  <= '0;
         changed_total_ff <= '0;
         column_total_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         column_peak_ff   <= column_peak_in;
         overall_peak_ff  <= overall_peak_in;
         changed_total_ff <= changed_total_in;
         column_total_ff  <= column_total_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CsrThreshold: threshold_ff  <= csr_wdata;
               CsrWeightsEn: weights_en_ff <= csr_wdata[0];
               default:      weights_en_ff <= weights_en_ff;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_ff       <= req_tdata[31:0];
         b_ff       <= req_tdata[63:32];
         weight_ff  <= req_tdata[95:64];
         col_end_ff <= req_tuser;
         mat_end_ff <= req_tlast;
      end
      acc_hi_ff   <= acc_hi_in;
      acc_lo_ff   <= acc_lo_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A column can only be counted as changed when it is also counted as closed.
   a_changed_le_total: assert property (@(posedge clock) disable iff (reset)
      changed_total_ff <= column_total_ff)
      else $error("changed count exceeds column count");

   // The column count saturates at the configured maximum.
   a_total_saturates: assert property (@(posedge clock) disable iff (reset)
      column_total_ff <= MaxCols)
      else $error("column count above maximum");

   // A new result word only appears after the emit state.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word raised outside emit");

   // Leaving the emit state always leaves the totals cleared.
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_free) |=> (column_total_ff == 16'd0 &&
                                           overall_peak_ff == 48'd0))
      else $error("totals not cleared after result");

endmodule
